@@ rtl/core/tcie_pkg.sv @@
`timescale 1ns / 1ps

package tcie_pkg;

    localparam int TCIE_MEMORY_WORDS = 4096;
    localparam int REG_COUNT         = 16;
    localparam int REG_AW            = $clog2(REG_COUNT);
    localparam int WORD_W            = 32;
    localparam int LBASE_W           = 24;
    localparam int PBASE_W           = 12;
    localparam int SLICE_W           = 8;
    localparam int WIDX_W            = 12;
    localparam int CFG_DATA_W        = 24;
    localparam int CFG_INDEX_W       = 2;
    // (24-bit offset >> 2) + 12-bit base fits in 23 bits
    localparam int XLATE_W           = LBASE_W - 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_LOGICAL_BASE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHYSICAL_BASE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROUND_ROBIN   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLICE_LEN     = 2'd3;

    localparam logic [3:0] OPC_LOAD  = 4'h0;
    localparam logic [3:0] OPC_STORE = 4'h1;
    localparam logic [3:0] OPC_ADD   = 4'h2;

    localparam logic ACTION_PRELOAD = 1'b1;

    typedef enum logic [2:0] {
        KIND_LOAD    = 3'd0,
        KIND_STORE   = 3'd1,
        KIND_ADD     = 3'd2,
        KIND_EXIT    = 3'd3,
        KIND_PRELOAD = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [REG_AW-1:0] reg_idx;
        logic              err;
        logic [WIDX_W-1:0] widx;
    } t_s1_ctl;

endpackage

@@ rtl/core/tcie_ram.sv @@
`timescale 1ns / 1ps

module tcie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/tcie_regfile.sv @@
`timescale 1ns / 1ps

module tcie_regfile
    import tcie_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [REG_AW-1:0] i_rd_addr_a,
    input  logic [REG_AW-1:0] i_rd_addr_b,
    input  logic              i_wr_en,
    input  logic [REG_AW-1:0] i_wr_addr,
    input  logic [WORD_W-1:0] i_wr_data,
    output logic [WORD_W-1:0] o_rd_data_a,
    output logic [WORD_W-1:0] o_rd_data_b
);

    logic [REG_COUNT-1:0] r_valid;
    logic                 r_fwd_a;
    logic                 r_fwd_b;
    logic                 r_zero_a;
    logic                 r_zero_b;
    logic [WORD_W-1:0]    r_fwd_data;
    logic [WORD_W-1:0]    ram_a;
    logic [WORD_W-1:0]    ram_b;
    logic                 hit_a;
    logic                 hit_b;

    // two copies give two read ports
    tcie_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_copy_a (
        .i_clk  (i_clk),
        .i_we   (i_wr_en),
        .i_waddr(i_wr_addr),
        .i_wdata(i_wr_data),
        .i_re   (i_rd_en),
        .i_raddr(i_rd_addr_a),
        .o_rdata(ram_a)
    );

    tcie_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_copy_b (
        .i_clk  (i_clk),
        .i_we   (i_wr_en),
        .i_waddr(i_wr_addr),
        .i_wdata(i_wr_data),
        .i_re   (i_rd_en),
        .i_raddr(i_rd_addr_b),
        .o_rdata(ram_b)
    );

    assign hit_a = i_wr_en && (i_wr_addr == i_rd_addr_a);
    assign hit_b = i_wr_en && (i_wr_addr == i_rd_addr_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_a    <= hit_a;
            r_fwd_b    <= hit_b;
            r_zero_a   <= !hit_a && !r_valid[i_rd_addr_a];
            r_zero_b   <= !hit_b && !r_valid[i_rd_addr_b];
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data_a = r_zero_a ? '0 : (r_fwd_a ? r_fwd_data : ram_a);
    assign o_rd_data_b = r_zero_b ? '0 : (r_fwd_b ? r_fwd_data : ram_b);

endmodule

@@ rtl/core/tcie_issue.sv @@
`timescale 1ns / 1ps

module tcie_issue
    import tcie_pkg::*;
#(
    parameter int MEMORY_WORDS = TCIE_MEMORY_WORDS,
    localparam int AW          = $clog2(MEMORY_WORDS)
) (
    input  logic               i_action,
    input  logic [WORD_W-1:0]  i_instruction_word,
    input  logic [WIDX_W-1:0]  i_preload_index,
    input  logic [LBASE_W-1:0] i_logical_base,
    input  logic [PBASE_W-1:0] i_physical_base,
    output t_s1_ctl            o_ctl,
    output logic [REG_AW-1:0]  o_rd_addr_a,
    output logic [REG_AW-1:0]  o_rd_addr_b,
    output logic [AW-1:0]      o_mem_idx,
    output logic               o_mem_ok
);

    logic [3:0]         opcode;
    logic [REG_AW-1:0]  reg_idx;
    logic [LBASE_W-1:0] addr;
    logic [LBASE_W-1:0] offset;
    logic [XLATE_W-1:0] xlate;
    logic               below;
    logic               in_range;
    logic               xlate_ok;
    logic [31:0]        pre_ext;
    logic               pre_ok;

    assign opcode  = i_instruction_word[31:28];
    assign reg_idx = i_instruction_word[27:24];
    assign addr    = i_instruction_word[23:0];

    assign below    = addr < i_logical_base;
    assign offset   = addr - i_logical_base;
    assign xlate    = XLATE_W'(offset[LBASE_W-1:2]) + XLATE_W'(i_physical_base);
    assign in_range = 32'(xlate) < 32'(MEMORY_WORDS);
    assign xlate_ok = !below && in_range;

    assign pre_ext = 32'(i_preload_index);
    assign pre_ok  = pre_ext < 32'(MEMORY_WORDS);

    // store reads its data register on port a
    assign o_rd_addr_a = (opcode == OPC_ADD) ? i_instruction_word[23:20] : reg_idx;
    assign o_rd_addr_b = i_instruction_word[19:16];

    always_comb begin
        o_ctl     = '{kind: KIND_EXIT, reg_idx: '0, err: 1'b0, widx: '0};
        o_mem_idx = xlate[AW-1:0];
        o_mem_ok  = 1'b0;
        if (i_action == ACTION_PRELOAD) begin
            o_ctl.kind = KIND_PRELOAD;
            o_mem_idx  = pre_ext[AW-1:0];
            o_mem_ok   = pre_ok;
        end else begin
            case (opcode)
                OPC_LOAD, OPC_STORE: begin
                    o_ctl.kind    = (opcode == OPC_LOAD) ? KIND_LOAD : KIND_STORE;
                    o_ctl.reg_idx = reg_idx;
                    o_ctl.err     = !xlate_ok;
                    o_ctl.widx    = xlate_ok ? xlate[WIDX_W-1:0] : '0;
                    o_mem_ok      = xlate_ok;
                end
                OPC_ADD: begin
                    o_ctl.kind    = KIND_ADD;
                    o_ctl.reg_idx = reg_idx;
                end
                default: begin
                    o_ctl.kind = KIND_EXIT;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/toy_core_instruction_executor.sv @@
`timescale 1ns / 1ps
// Channel  Handshake                 Payload
// in       i_in_valid / o_in_stall   i_action, i_instruction_word, i_preload_index,
//                                    i_preload_value
// out      o_out_valid / i_out_stall o_op_kind, o_register_index, o_result_value,
//                                    o_word_index, o_address_error, o_slice_end
// cfg      i_cfg_we                  i_cfg_index, i_cfg_data
//
// One instruction per cycle unless the output stalls; items pass the execute
// stage register, then the result register. Data memory and register file reads
// launch at input transfer and complete in execute, where all writes happen.
// Synchronous active-low reset clears control state only; no clearing pass.
// An output stall holds the result register and then the execute stage.

module toy_core_instruction_executor
    import tcie_pkg::*;
#(
    parameter int MEMORY_WORDS = TCIE_MEMORY_WORDS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_action,
    input  logic [WORD_W-1:0]       i_instruction_word,
    input  logic [WIDX_W-1:0]       i_preload_index,
    input  logic signed [WORD_W-1:0] i_preload_value,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [2:0]              o_op_kind,
    output logic [REG_AW-1:0]       o_register_index,
    output logic signed [WORD_W-1:0] o_result_value,
    output logic [WIDX_W-1:0]       o_word_index,
    output logic                    o_address_error,
    output logic                    o_slice_end
);

    localparam int AW = $clog2(MEMORY_WORDS);

    logic [LBASE_W-1:0] r_logical_base;
    logic [PBASE_W-1:0] r_physical_base;
    logic               r_round_robin;
    logic [SLICE_W-1:0] r_slice_len;
    logic [SLICE_W-1:0] r_slice_count;
    logic [SLICE_W-1:0] n_slice_count;

    logic               r_s1_valid;
    t_s1_ctl            r_s1;
    logic [AW-1:0]      r_s1_mem_idx;
    logic               r_s1_mem_ok;
    logic [WORD_W-1:0]  r_s1_pre_value;
    logic               r_mfwd;
    logic [WORD_W-1:0]  r_mfwd_data;

    logic               r_out_valid;
    t_kind              r_out_kind;
    logic [REG_AW-1:0]  r_out_reg;
    logic [WORD_W-1:0]  r_out_value;
    logic [WIDX_W-1:0]  r_out_widx;
    logic               r_out_err;
    logic               r_out_send;

    t_s1_ctl            iss_ctl;
    logic [REG_AW-1:0]  iss_rd_a;
    logic [REG_AW-1:0]  iss_rd_b;
    logic [AW-1:0]      iss_mem_idx;
    logic               iss_mem_ok;

    logic               in_xfer;
    logic               out_free;
    logic               s1_adv;
    logic [WORD_W-1:0]  reg_a;
    logic [WORD_W-1:0]  reg_b;
    logic [WORD_W-1:0]  mem_rdata;
    logic [WORD_W-1:0]  load_data;
    logic [WORD_W-1:0]  value;
    logic               rf_we;
    logic               mem_we;
    logic [WORD_W-1:0]  mem_wdata;
    logic [SLICE_W:0]   slice_next;
    logic               send;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    tcie_issue #(.MEMORY_WORDS(MEMORY_WORDS)) u_issue (
        .i_action          (i_action),
        .i_instruction_word(i_instruction_word),
        .i_preload_index   (i_preload_index),
        .i_logical_base    (r_logical_base),
        .i_physical_base   (r_physical_base),
        .o_ctl             (iss_ctl),
        .o_rd_addr_a       (iss_rd_a),
        .o_rd_addr_b       (iss_rd_b),
        .o_mem_idx         (iss_mem_idx),
        .o_mem_ok          (iss_mem_ok)
    );

    tcie_regfile u_regfile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_xfer),
        .i_rd_addr_a(iss_rd_a),
        .i_rd_addr_b(iss_rd_b),
        .i_wr_en    (rf_we),
        .i_wr_addr  (r_s1.reg_idx),
        .i_wr_data  (value),
        .o_rd_data_a(reg_a),
        .o_rd_data_b(reg_b)
    );

    tcie_ram #(.WIDTH(WORD_W), .DEPTH(MEMORY_WORDS)) u_data_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(r_s1_mem_idx),
        .i_wdata(mem_wdata),
        .i_re   (in_xfer),
        .i_raddr(iss_mem_idx),
        .o_rdata(mem_rdata)
    );

    // execute stage
    assign load_data = r_mfwd ? r_mfwd_data : mem_rdata;

    always_comb begin
        value = '0;
        case (r_s1.kind)
            KIND_LOAD:  value = r_s1.err ? '0 : load_data;
            KIND_STORE: value = r_s1.err ? '0 : reg_a;
            KIND_ADD:   value = reg_a + reg_b;
            default:    value = '0;
        endcase
    end

    assign rf_we = s1_adv && (((r_s1.kind == KIND_LOAD) && !r_s1.err) || (r_s1.kind == KIND_ADD));
    assign mem_we = s1_adv && r_s1_mem_ok &&
                    ((r_s1.kind == KIND_STORE) || (r_s1.kind == KIND_PRELOAD));
    assign mem_wdata = (r_s1.kind == KIND_PRELOAD) ? r_s1_pre_value : reg_a;

    // a zero slice length behaves as one
    assign slice_next = {1'b0, r_slice_count} + (SLICE_W+1)'(1);

    always_comb begin
        n_slice_count = r_slice_count;
        send          = 1'b0;
        if (r_s1.kind == KIND_PRELOAD) begin
            n_slice_count = r_slice_count;
        end else if ((r_s1.kind == KIND_EXIT) || !r_round_robin) begin
            n_slice_count = '0;
        end else if (slice_next >= {1'b0, r_slice_len}) begin
            n_slice_count = '0;
            send          = 1'b1;
        end else begin
            n_slice_count = slice_next[SLICE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_logical_base  <= '0;
            r_physical_base <= '0;
            r_round_robin   <= 1'b1;
            r_slice_len     <= SLICE_W'(8);
            r_slice_count   <= '0;
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LOGICAL_BASE:  r_logical_base  <= i_cfg_data[LBASE_W-1:0];
                    CFG_PHYSICAL_BASE: r_physical_base <= i_cfg_data[PBASE_W-1:0];
                    CFG_ROUND_ROBIN:   r_round_robin   <= i_cfg_data[0];
                    CFG_SLICE_LEN:     r_slice_len     <= i_cfg_data[SLICE_W-1:0];
                    default: ;
                endcase
            end
            if (s1_adv) begin
                r_slice_count <= n_slice_count;
            end
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1           <= iss_ctl;
            r_s1_mem_idx   <= iss_mem_idx;
            r_s1_mem_ok    <= iss_mem_ok;
            r_s1_pre_value <= i_preload_value;
            r_mfwd         <= mem_we && (r_s1_mem_idx == iss_mem_idx);
            r_mfwd_data    <= mem_wdata;
        end
        if (s1_adv) begin
            r_out_kind  <= r_s1.kind;
            r_out_reg   <= r_s1.reg_idx;
            r_out_value <= value;
            r_out_widx  <= r_s1.widx;
            r_out_err   <= r_s1.err;
            r_out_send  <= send;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_op_kind        = r_out_kind;
    assign o_register_index = r_out_reg;
    assign o_result_value   = r_out_value;
    assign o_word_index     = r_out_widx;
    assign o_address_error  = r_out_err;
    assign o_slice_end      = r_out_send;

`ifndef SYNTHESIS
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with empty execute stage");

    a_adv_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> o_out_valid)
        else $error("executed item produced no result");

    a_err_no_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_address_error) |-> (o_result_value == '0 && o_word_index == '0))
        else $error("address error with access data");

    a_slice_rr_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_slice_end) |-> (r_round_robin &&
            o_op_kind != KIND_EXIT && o_op_kind != KIND_PRELOAD))
        else $error("slice end outside round-robin execution");
`endif

endmodule

@@ sim/tcie_checker.sv @@
`timescale 1ns / 1ps

module tcie_checker
    import tcie_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic                   i_action,
    input  logic [WORD_W-1:0]      i_instruction_word,
    input  logic [WIDX_W-1:0]      i_preload_index,
    input  logic [WORD_W-1:0]      i_preload_value,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [2:0]             i_op_kind,
    input  logic [REG_AW-1:0]      i_register_index,
    input  logic [WORD_W-1:0]      i_result_value,
    input  logic [WIDX_W-1:0]      i_word_index,
    input  logic                   i_address_error,
    input  logic                   i_slice_end,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        t_kind             kind;
        logic [REG_AW-1:0] reg_idx;
        logic [WORD_W-1:0] value;
        logic [WIDX_W-1:0] widx;
        logic              err;
        logic              slice_end;
    } t_exec_result;

    logic [LBASE_W-1:0] logical_base;
    logic [PBASE_W-1:0] physical_base;
    logic               round_robin;
    logic [SLICE_W-1:0] slice_len;

    logic [WORD_W-1:0]  gpr [REG_COUNT];
    logic [WORD_W-1:0]  data_mem [TCIE_MEMORY_WORDS];
    logic [SLICE_W-1:0] slice_count;

    t_exec_result results_due [$];
    int           fails;

    function automatic bit translate(input logic [LBASE_W-1:0] addr, output int idx);
        int word_idx;
        idx = 0;
        if (addr < logical_base)
            return 1'b0;
        word_idx = int'((addr - logical_base) >> 2) + int'(physical_base);
        if (word_idx >= TCIE_MEMORY_WORDS)
            return 1'b0;
        idx = word_idx;
        return 1'b1;
    endfunction

    function automatic t_exec_result execute_item(input logic action,
                                                  input logic [WORD_W-1:0] word,
                                                  input logic [WIDX_W-1:0] pidx,
                                                  input logic [WORD_W-1:0] pval);
        t_exec_result r;
        logic [3:0]   opc;
        logic [3:0]   rd;
        int           idx;
        logic [SLICE_W:0] next_count;
        r = '0;
        if (action == ACTION_PRELOAD) begin
            data_mem[pidx] = pval;
            r.kind = KIND_PRELOAD;
            return r;
        end
        opc = word[31:28];
        rd  = word[27:24];
        if (opc == OPC_LOAD || opc == OPC_STORE) begin
            r.kind    = (opc == OPC_LOAD) ? KIND_LOAD : KIND_STORE;
            r.reg_idx = rd;
            if (translate(word[23:0], idx)) begin
                if (opc == OPC_LOAD) begin
                    r.value = data_mem[idx];
                    gpr[rd] = r.value;
                end else begin
                    r.value       = gpr[rd];
                    data_mem[idx] = r.value;
                end
                r.widx = idx[WIDX_W-1:0];
            end else begin
                r.err = 1'b1;
            end
        end else if (opc == OPC_ADD) begin
            r.kind    = KIND_ADD;
            r.reg_idx = rd;
            r.value   = gpr[word[23:20]] + gpr[word[19:16]];
            gpr[rd]   = r.value;
        end else begin
            r.kind = KIND_EXIT;
        end
        // a zero slice length ends every slice
        if (r.kind == KIND_EXIT || !round_robin) begin
            slice_count = '0;
        end else begin
            next_count = {1'b0, slice_count} + (SLICE_W+1)'(1);
            if (next_count >= {1'b0, slice_len}) begin
                r.slice_end = 1'b1;
                slice_count = '0;
            end else begin
                slice_count = next_count[SLICE_W-1:0];
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] expected,
                               input logic [WORD_W-1:0] actual);
        if (actual !== expected) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, expected, actual);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_exec_result due;
        if (!i_rst_n) begin
            logical_base  = '0;
            physical_base = '0;
            round_robin   = 1'b1;
            slice_len     = 8'd8;
            slice_count   = '0;
            for (int k = 0; k < REG_COUNT; k++)
                gpr[k] = '0;
            results_due.delete();
            fails = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result transfer with nothing outstanding (kind %0d)",
                             $time, i_op_kind);
                    fails++;
                end else begin
                    due = results_due.pop_front();
                    check_field("op_kind", due.kind, i_op_kind);
                    check_field("register_index", due.reg_idx, i_register_index);
                    check_field("result_value", due.value, i_result_value);
                    check_field("word_index", due.widx, i_word_index);
                    check_field("address_error", due.err, i_address_error);
                    check_field("slice_end", due.slice_end, i_slice_end);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LOGICAL_BASE:  logical_base  = i_cfg_data[LBASE_W-1:0];
                    CFG_PHYSICAL_BASE: physical_base = i_cfg_data[PBASE_W-1:0];
                    CFG_ROUND_ROBIN:   round_robin   = i_cfg_data[0];
                    CFG_SLICE_LEN:     slice_len     = i_cfg_data[SLICE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                results_due.push_back(execute_item(i_action, i_instruction_word,
                                                   i_preload_index, i_preload_value));
        end
        o_fail_count <= fails;
        o_pending    <= results_due.size();
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import tcie_pkg::*;

    localparam logic       ACTION_EXECUTE = 1'b0;
    localparam logic [3:0] OPC_EXIT       = 4'h3;
    localparam logic [3:0] OPC_LAST       = 4'hF;
    localparam int         ADDR_LIMIT     = 'hFF_FFFF;
    localparam int         IDLE_LIMIT     = 1000;
    localparam int         DRAIN_CYCLES   = 8;

    logic                     i_clk              = 1'b0;
    logic                     i_rst_n            = 1'b0;
    logic                     i_cfg_we           = 1'b0;
    logic [CFG_INDEX_W-1:0]   i_cfg_index        = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data         = '0;
    logic                     i_in_valid         = 1'b0;
    logic                     o_in_stall;
    logic                     i_action           = 1'b0;
    logic [WORD_W-1:0]        i_instruction_word = '0;
    logic [WIDX_W-1:0]        i_preload_index    = '0;
    logic signed [WORD_W-1:0] i_preload_value    = '0;
    logic                     o_out_valid;
    logic                     i_out_stall        = 1'b0;
    logic [2:0]               o_op_kind;
    logic [REG_AW-1:0]        o_register_index;
    logic signed [WORD_W-1:0] o_result_value;
    logic [WIDX_W-1:0]        o_word_index;
    logic                     o_address_error;
    logic                     o_slice_end;

    int fail_count;
    int pending;

    // stimulus side: current bases and which data words hold a value
    int lbase;
    int pbase;
    bit written [TCIE_MEMORY_WORDS];
    int written_list [$];

    bit gaps_on     = 1'b1;
    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_timer = 0;
    int idle_cycles = 0;
    int sent_by_kind [5];
    int faults_sent = 0;
    int phases_run  = 0;

    always #2 i_clk = ~i_clk;

    toy_core_instruction_executor dut (.*);

    tcie_checker exec_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_action           (i_action),
        .i_instruction_word (i_instruction_word),
        .i_preload_index    (i_preload_index),
        .i_preload_value    (i_preload_value),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_op_kind          (o_op_kind),
        .i_register_index   (o_register_index),
        .i_result_value     (o_result_value),
        .i_word_index       (o_word_index),
        .i_address_error    (o_address_error),
        .i_slice_end        (o_slice_end),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // receiver: free-running, random and periodic stall stretches
    always @(posedge i_clk) begin
        if (stall_timer == 0) begin
            stall_mode  <= $urandom_range(0, 2);
            stall_timer <= $urandom_range(20, 120);
        end else begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            default: i_out_stall <= (stall_timer % 5 < 2);
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("FAIL toy_core_instruction_executor");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic void note_written(input int w);
        if (!written[w]) begin
            written[w] = 1'b1;
            written_list.push_back(w);
        end
    endfunction

    function automatic bit maps_to(input int addr, output int idx);
        idx = ((addr - lbase) >> 2) + pbase;
        return addr >= lbase && idx < TCIE_MEMORY_WORDS;
    endfunction

    function automatic int window_top();
        int top_idx;
        top_idx = pbase + ((ADDR_LIMIT - lbase) >> 2);
        return (top_idx < TCIE_MEMORY_WORDS) ? top_idx : TCIE_MEMORY_WORDS - 1;
    endfunction

    function automatic int addr_for(input int w);
        int base_addr;
        int offs;
        base_addr = lbase + 4 * (w - pbase);
        offs      = $urandom_range(0, 3);
        return (base_addr + offs > ADDR_LIMIT) ? base_addr : base_addr + offs;
    endfunction

    // below the logical base, or translating to an index past the memory
    function automatic int fault_addr();
        int beyond;
        beyond = lbase + 4 * (TCIE_MEMORY_WORDS - pbase);
        if (lbase > 0 && (beyond > ADDR_LIMIT || $urandom_range(0, 1) == 0))
            return $urandom_range(0, lbase - 1);
        return $urandom_range(beyond, ADDR_LIMIT);
    endfunction

    task automatic send_item(input t_kind kind, input logic action,
                             input logic [WORD_W-1:0] word,
                             input logic [WIDX_W-1:0] pidx,
                             input logic [WORD_W-1:0] pval);
        i_in_valid         <= 1'b1;
        i_action           <= action;
        i_instruction_word <= word;
        i_preload_index    <= pidx;
        i_preload_value    <= pval;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sent_by_kind[kind]++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 16);
            if (gaps_on) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic configure(input int lb, input int pb, input bit rr, input int sl);
        wait_drained();
        write_reg(CFG_LOGICAL_BASE, CFG_DATA_W'(lb));
        write_reg(CFG_PHYSICAL_BASE, CFG_DATA_W'(pb));
        write_reg(CFG_ROUND_ROBIN, CFG_DATA_W'(rr));
        write_reg(CFG_SLICE_LEN, CFG_DATA_W'(sl));
        i_cfg_we <= 1'b0;
        lbase = lb;
        pbase = pb;
        phases_run++;
    endtask

    task automatic random_item();
        int          pick;
        int          w;
        int          addr;
        int          idx;
        logic [31:0] word;
        logic [31:0] value;
        word = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            if ($urandom_range(0, 9) < 7)
                w = $urandom_range(pbase, window_top());
            else
                w = $urandom_range(0, TCIE_MEMORY_WORDS - 1);
            case ($urandom_range(0, 11))
                0:       value = 32'h8000_0000;
                1:       value = 32'h7FFF_FFFF;
                2:       value = 32'hFFFF_FFFF;
                3:       value = '0;
                default: value = $urandom();
            endcase
            note_written(w);
            send_item(KIND_PRELOAD, ACTION_PRELOAD, word, WIDX_W'(w), value);
        end else if (pick < 40) begin
            addr = -1;
            if (written_list.size() > 0 && $urandom_range(0, 4) != 0) begin
                for (int t = 0; t < 8 && addr < 0; t++) begin
                    w = written_list[$urandom_range(0, written_list.size() - 1)];
                    if (w >= pbase && w <= window_top())
                        addr = addr_for(w);
                end
            end
            if (addr < 0) begin
                addr = fault_addr();
                faults_sent++;
            end
            send_item(KIND_LOAD, ACTION_EXECUTE, {OPC_LOAD, word[27:24], addr[23:0]},
                      WIDX_W'($urandom()), $urandom());
        end else if (pick < 65) begin
            case ($urandom_range(0, 3))
                0, 1:    addr = addr_for($urandom_range(pbase, window_top()));
                2:       addr = fault_addr();
                default: addr = $urandom_range(0, ADDR_LIMIT);
            endcase
            if (maps_to(addr, idx))
                note_written(idx);
            else
                faults_sent++;
            send_item(KIND_STORE, ACTION_EXECUTE, {OPC_STORE, word[27:24], addr[23:0]},
                      WIDX_W'($urandom()), $urandom());
        end else if (pick < 88) begin
            send_item(KIND_ADD, ACTION_EXECUTE, {OPC_ADD, word[27:0]},
                      WIDX_W'($urandom()), $urandom());
        end else begin
            send_item(KIND_EXIT, ACTION_EXECUTE,
                      {4'($urandom_range(OPC_EXIT, OPC_LAST)), word[27:0]},
                      WIDX_W'($urandom()), $urandom());
        end
    endtask

    task automatic run_random(input int count, input bit with_gaps);
        gaps_on = with_gaps;
        repeat (count) random_item();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        configure(0, 0, 1'b1, 8);
        send_item(KIND_PRELOAD, ACTION_PRELOAD, '1, 12'd0, 32'h7FFF_FFFF);
        send_item(KIND_PRELOAD, ACTION_PRELOAD, '0, 12'hFFF, 32'h8000_0000);
        send_item(KIND_PRELOAD, ACTION_PRELOAD, '0, 12'd1, 32'hFFFF_FFFF);
        send_item(KIND_PRELOAD, ACTION_PRELOAD, '0, 12'd2, 32'd1);
        note_written(0);
        note_written(1);
        note_written(2);
        note_written(TCIE_MEMORY_WORDS - 1);
        send_item(KIND_LOAD, ACTION_EXECUTE, {OPC_LOAD, 4'h0, 24'h00_0000}, '1, '1);
        send_item(KIND_LOAD, ACTION_EXECUTE, {OPC_LOAD, 4'hF, 24'h00_3FFF}, '0, '0);
        send_item(KIND_LOAD, ACTION_EXECUTE, {OPC_LOAD, 4'h1, 24'h00_0004}, '0, '0);
        send_item(KIND_LOAD, ACTION_EXECUTE, {OPC_LOAD, 4'h2, 24'h00_0008}, '0, '0);
        // signed wrap both ways, then zero plus zero
        send_item(KIND_ADD, ACTION_EXECUTE, {OPC_ADD, 4'h3, 4'h0, 4'h2, 16'hFFFF}, '0, '0);
        send_item(KIND_ADD, ACTION_EXECUTE, {OPC_ADD, 4'h4, 4'hF, 4'h1, 16'h0000}, '0, '0);
        send_item(KIND_ADD, ACTION_EXECUTE, {OPC_ADD, 4'h5, 4'h5, 4'h5, 16'h0000}, '0, '0);
        send_item(KIND_STORE, ACTION_EXECUTE, {OPC_STORE, 4'h3, 24'h00_0010}, '0, '0);
        note_written(4);
        send_item(KIND_LOAD, ACTION_EXECUTE, {OPC_LOAD, 4'h6, 24'h00_0013}, '0, '0);
        send_item(KIND_LOAD, ACTION_EXECUTE, {OPC_LOAD, 4'h7, 24'hFF_FFFF}, '0, '0);
        send_item(KIND_STORE, ACTION_EXECUTE, {OPC_STORE, 4'h4, 24'h00_4000}, '0, '0);
        send_item(KIND_EXIT, ACTION_EXECUTE, {OPC_EXIT, 28'h000_0000}, '0, '0);
        send_item(KIND_EXIT, ACTION_EXECUTE, {OPC_LAST, 28'hFFF_FFFF}, '0, '0);
        faults_sent += 2;
        run_random(150, 1'b1);

        configure('h100, 'h010, 1'b1, 1);
        send_item(KIND_PRELOAD, ACTION_PRELOAD, '0, 12'h010, 32'h1234_5678);
        note_written('h010);
        send_item(KIND_LOAD, ACTION_EXECUTE, {OPC_LOAD, 4'h8, 24'h00_0100}, '0, '0);
        send_item(KIND_LOAD, ACTION_EXECUTE, {OPC_LOAD, 4'h9, 24'h00_00FF}, '0, '0);
        send_item(KIND_STORE, ACTION_EXECUTE, {OPC_STORE, 4'h9, 24'h00_0000}, '0, '0);
        faults_sent += 2;
        run_random(150, 1'b1);

        configure(ADDR_LIMIT, TCIE_MEMORY_WORDS - 1, 1'b1, 255);
        run_random(100, 1'b0);

        configure($urandom_range(0, ADDR_LIMIT) >> $urandom_range(0, 20),
                  $urandom_range(0, 4095), 1'b0, $urandom_range(1, 255));
        run_random(150, 1'b1);

        // slice length zero behaves as one
        configure('h400, 'hF00, 1'b1, 0);
        run_random(150, 1'b1);

        configure(0, TCIE_MEMORY_WORDS - 1, 1'b1, 3);
        run_random(100, 1'b0);

        repeat (3) begin
            configure($urandom_range(0, ADDR_LIMIT) >> $urandom_range(0, 20),
                      $urandom_range(0, 4095), 1'($urandom_range(0, 1)),
                      $urandom_range(1, 255));
            run_random(170, 1'b1);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d loads, %0d stores, %0d adds, %0d exits, %0d preloads in %0d setups;",
                 sent_by_kind[KIND_LOAD], sent_by_kind[KIND_STORE], sent_by_kind[KIND_ADD],
                 sent_by_kind[KIND_EXIT], sent_by_kind[KIND_PRELOAD], phases_run);
        $display("%0d load/store transfers carried an out-of-range address.", faults_sent);
        if (fail_count == 0)
            $display("PASS toy_core_instruction_executor");
        else
            $display("FAIL toy_core_instruction_executor");
        $finish;
    end

endmodule
